/* rtl/pwmtf_pkg.sv */
// ----------------------------------------------------------------------------
// pwmtf_pkg
// Types and constants shared by the pwm timing calculator and its checker.
// ----------------------------------------------------------------------------
package pwmtf_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 5;

  localparam int unsigned FREQ_W = 26;
  localparam int unsigned DUTY_W = 7;
  localparam int unsigned CHAN_W = 3;
  localparam int unsigned PRE_W  = 13;
  localparam int unsigned CNT_W  = 12;

  localparam logic [FREQ_W-1:0] FREQ_LIMIT = 26'd41800000;
  localparam logic [FREQ_W-1:0] FAST_ABOVE = 26'd10000;
  localparam int unsigned       STEPS_LOG2 = 12;

  localparam int unsigned CLK_W = 29;
  localparam logic [CLK_W-1:0] CLK_FAST = 29'd418000000;
  localparam logic [CLK_W-1:0] CLK_SLOW = 29'd27000000;

  // source clock over 4096, the prescaler dividend
  localparam int unsigned QN_W = 17;
  localparam logic [QN_W-1:0] QN_FAST = QN_W'(CLK_FAST >> STEPS_LOG2);
  localparam logic [QN_W-1:0] QN_SLOW = QN_W'(CLK_SLOW >> STEPS_LOG2);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // divide by 100 as a multiply by a scaled reciprocal
  localparam int unsigned RECIP_SH = 27;
  localparam int unsigned RECIP_W  = 21;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((1 << RECIP_SH) + 99) / 100);

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              enable;
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty_percent;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [CHAN_W-1:0] channel_out;
    logic              enable_out;
    logic              clock_select;
    logic [PRE_W-1:0]  prescale;
    logic [CNT_W-1:0]  period_count;
    logic [CNT_W-1:0]  high_count;
  } rsp_t;

  // fields that ride along the pipeline untouched
  typedef struct packed {
    logic              ok;
    logic [CHAN_W-1:0] channel;
    logic              enable;
    logic              sel;
    logic [DUTY_W-1:0] duty;
  } ctl_t;

endpackage

/* rtl/pwm_timing_from_freq_duty.sv */
// ----------------------------------------------------------------------------
// pwm_timing_from_freq_duty
// Turns a frequency and duty request into prescaler, period and high counts.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | beat
//   req     | in        | req_valid, req_stall | req_t: channel, enable, freq, duty
//   rsp     | out       | rsp_valid, rsp_stall | rsp_t: ok, echoes, select, counts
//
// one beat per cycle in, one per cycle out while no result is stalled at the output;
// built around two restoring dividers (13 prescaler stages, 12 period stages, one bit each)
// rst clears every stage valid; payload registers are not reset
// rsp_stall freezes the whole pipeline and is passed back as req_stall while
// a result is waiting at the output
module pwm_timing_from_freq_duty #(
  parameter int unsigned NUM_CHANNELS = pwmtf_pkg::NUM_CHANNELS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pwmtf_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pwmtf_pkg::rsp_t rsp
);
  import pwmtf_pkg::*;

  localparam int unsigned D_W = FREQ_W + PRE_W;

  logic adv;
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = rsp_valid && rsp_stall;

  // prescaler divider stages
  logic              a_v   [0:PRE_W];
  ctl_t              a_c   [0:PRE_W];
  logic [FREQ_W-1:0] a_f   [0:PRE_W];
  logic [QN_W-1:0]   a_rem [0:PRE_W];
  logic [PRE_W-1:0]  a_q   [0:PRE_W];

  // period divider stages
  logic              b_v   [0:CNT_W];
  ctl_t              b_c   [0:CNT_W];
  logic [D_W-1:0]    b_d   [0:CNT_W];
  logic [CLK_W-1:0]  b_rem [0:CNT_W];
  logic [CNT_W-1:0]  b_q   [0:CNT_W];
  logic [PRE_W-1:0]  b_pre [0:CNT_W];

  // entry stage: range check and source pick
  logic bad;
  logic fast;
  assign bad  = (req.freq_hz == '0) || (req.freq_hz > FREQ_LIMIT) ||
                ({1'b0, req.channel} >= (CHAN_W+1)'(NUM_CHANNELS));
  assign fast = req.freq_hz > FAST_ABOVE;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v[0] <= 1'b0;
    end else if (adv) begin
      a_v[0] <= req_valid;
    end
    if (adv) begin
      a_c[0].ok      <= !bad;
      a_c[0].channel <= req.channel;
      a_c[0].enable  <= req.enable;
      a_c[0].sel     <= fast;
      a_c[0].duty    <= req.duty_percent;
      // a rejected beat divides by one so the datapath stays tame
      a_f[0]   <= bad ? FREQ_W'(1) : req.freq_hz;
      a_rem[0] <= fast ? QN_FAST : QN_SLOW;
      a_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < PRE_W; k++) begin : g_pre
    localparam int unsigned BIT = PRE_W - 1 - k;
    logic [D_W-1:0] sub;
    logic           take;
    assign sub  = D_W'(a_f[k]) << BIT;
    assign take = D_W'(a_rem[k]) >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[k+1] <= 1'b0;
      end else if (adv) begin
        a_v[k+1] <= a_v[k];
      end
      if (adv) begin
        a_c[k+1]   <= a_c[k];
        a_f[k+1]   <= a_f[k];
        a_rem[k+1] <= take ? QN_W'(D_W'(a_rem[k]) - sub) : a_rem[k];
        a_q[k+1]   <= a_q[k] | (take ? (PRE_W'(1) << BIT) : '0);
      end
    end
  end

  // divisor for the period: freq * (prescale + 1)
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v[0] <= 1'b0;
    end else if (adv) begin
      b_v[0] <= a_v[PRE_W];
    end
    if (adv) begin
      b_c[0]   <= a_c[PRE_W];
      b_d[0]   <= D_W'(a_f[PRE_W]) * (D_W'(a_q[PRE_W]) + D_W'(1));
      b_rem[0] <= a_c[PRE_W].sel ? CLK_FAST : CLK_SLOW;
      b_q[0]   <= '0;
      b_pre[0] <= a_q[PRE_W];
    end
  end

  for (genvar k = 0; k < CNT_W; k++) begin : g_per
    localparam int unsigned BIT = CNT_W - 1 - k;
    localparam int unsigned SW  = D_W + CNT_W;
    logic [SW-1:0] sub;
    logic          take;
    assign sub  = SW'(b_d[k]) << BIT;
    assign take = SW'(b_rem[k]) >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        b_v[k+1] <= 1'b0;
      end else if (adv) begin
        b_v[k+1] <= b_v[k];
      end
      if (adv) begin
        b_c[k+1]   <= b_c[k];
        b_d[k+1]   <= b_d[k];
        b_rem[k+1] <= take ? CLK_W'(SW'(b_rem[k]) - sub) : b_rem[k];
        b_q[k+1]   <= b_q[k] | (take ? (CNT_W'(1) << BIT) : '0);
        b_pre[k+1] <= b_pre[k];
      end
    end
  end

  // period and the duty product
  localparam int unsigned X_W = CNT_W + 1 + DUTY_W;
  localparam int unsigned P_W = X_W + RECIP_W;
  localparam int unsigned H_W = CNT_W + 1;

  logic              p_v;
  ctl_t              p_c;
  logic [PRE_W-1:0]  p_pre;
  logic [CNT_W-1:0]  p_per;
  logic [X_W-1:0]    p_x;
  logic [CNT_W-1:0]  per_next;

  assign per_next = (b_q[CNT_W] == '0) ? '0 : b_q[CNT_W] - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= b_v[CNT_W];
    end
    if (adv) begin
      p_c   <= b_c[CNT_W];
      p_pre <= b_pre[CNT_W];
      p_per <= per_next;
      p_x   <= (X_W'(per_next) + X_W'(1)) * X_W'(b_c[CNT_W].duty);
    end
  end

  // divide by 100
  logic              r_v;
  ctl_t              r_c;
  logic [PRE_W-1:0]  r_pre;
  logic [CNT_W-1:0]  r_per;
  logic [H_W-1:0]    r_hi;
  logic [P_W-1:0]    prod;

  assign prod = P_W'(p_x) * P_W'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (adv) begin
      r_v <= p_v;
    end
    if (adv) begin
      r_c   <= p_c;
      r_pre <= p_pre;
      r_per <= p_per;
      r_hi  <= prod[RECIP_SH +: H_W];
    end
  end

  // output register
  logic [H_W-1:0]   hi_dec;
  logic [CNT_W-1:0] hi_sat;
  assign hi_dec = (r_hi == '0) ? '0 : r_hi - H_W'(1);
  assign hi_sat = (hi_dec > H_W'(COUNT_MAX)) ? COUNT_MAX : hi_dec[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= r_v;
    end
    if (adv) begin
      rsp.ok           <= r_c.ok;
      rsp.channel_out  <= r_c.channel;
      rsp.enable_out   <= r_c.enable;
      rsp.clock_select <= r_c.ok & r_c.sel;
      rsp.prescale     <= r_c.ok ? r_pre : '0;
      rsp.period_count <= r_c.ok ? r_per : '0;
      rsp.high_count   <= r_c.ok ? hi_sat : '0;
    end
  end

endmodule

/* rtl/pwmtf_check.sv */
// ----------------------------------------------------------------------------
// pwmtf_check
// Port-level checks for the pwm timing calculator.
// ----------------------------------------------------------------------------
module pwmtf_check (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input pwmtf_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input pwmtf_pkg::rsp_t rsp
);
  import pwmtf_pkg::*;

  // a held result beat keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed under stall");

  // back pressure only comes from a waiting result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("req_stall without a stalled result");

  // rejected beats carry zero settings
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.clock_select == 1'b0 && rsp.prescale == '0 &&
      rsp.period_count == '0 && rsp.high_count == '0)
    else $error("rejected beat has nonzero settings");

  // the fast source never needs a large prescaler
  a_fast_pre: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.ok && rsp.clock_select |-> rsp.prescale <= PRE_W'(10))
    else $error("prescaler out of range for the fast source");

  // period count never reaches the top code on a good beat
  a_period_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.ok |-> rsp.period_count != COUNT_MAX)
    else $error("period count out of range");

endmodule

bind pwm_timing_from_freq_duty pwmtf_check u_pwmtf_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
